>>> design/rv32i_exu_pkg.sv
// Shared types and constants for the RV32I integer execute unit.
package rv32i_exu_pkg;

    localparam int MEM_BYTES_DEF = 4096;
    localparam int REG_COUNT_DEF = 32;

    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] F7_ALT     = 7'h20;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_UNSUP   = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;

    typedef struct packed {
        logic [6:0]  major_opcode;
        logic [2:0]  func_three;
        logic [6:0]  func_seven;
        logic [4:0]  dest_reg;
        logic [4:0]  src_reg_a;
        logic [4:0]  src_reg_b;
        logic signed [31:0] immediate;
    } exu_in_t;

    typedef struct packed {
        logic [31:0] next_pc;
        logic        reg_written;
        logic [4:0]  written_index;
        logic [31:0] written_value;
        logic [1:0]  exec_status;
    } exu_out_t;

endpackage

>>> design/rv32i_integer_execute_unit.sv
// Top level of the RV32I integer execute unit: register file, data memory, execute logic.
// A word accepted into the stage 1 registers (operands and memory bytes are read at
// acceptance) shows its result word once execute writes the output register.
// Throughput: one word per cycle; it stalls only on a full output register that the
// consumer has not taken, or during the clearing pass. Reset: the PC clears at once; a
// clearing pass then sweeps the four byte banks in parallel with s_ready low.
module rv32i_integer_execute_unit #(
    parameter int MEM_BYTES = rv32i_exu_pkg::MEM_BYTES_DEF,
    parameter int REG_COUNT = rv32i_exu_pkg::REG_COUNT_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  rv32i_exu_pkg::exu_in_t  s_data,
    output logic                    m_valid,
    input  logic                    m_ready,
    output rv32i_exu_pkg::exu_out_t m_data
);

    localparam int AW = $clog2(MEM_BYTES);

    // Data memory: four byte banks interleaved on address bits [1:0] so that one word
    // access, aligned or not, touches each bank at most once.
    localparam int BANK_DEPTH = MEM_BYTES / 4;
    localparam int BW = AW - 2;

    logic [7:0] bank0 [BANK_DEPTH];
    logic [7:0] bank1 [BANK_DEPTH];
    logic [7:0] bank2 [BANK_DEPTH];
    logic [7:0] bank3 [BANK_DEPTH];

    // Register file, 32 words, with one valid bit each so reset reads as zero.
    logic [31:0] rf_mem [32];
    logic [31:0] rf_vld_reg;

    logic        clr_busy_reg;
    logic [BW:0] clr_cnt_reg;

    logic [31:0] pc_reg;

    // Stage 1 (read stage) registers.
    logic                   s1_vld_reg;
    rv32i_exu_pkg::exu_in_t s1_reg;

    logic [31:0] a_next, b_next, a_reg, b_reg;
    logic [31:0] addr;
    logic [7:0]  bq [4];
    logic        adv;
    logic        out_free;

    // Execute stage results.
    logic [31:0] val, npc;
    logic        wr, st_en;
    logic [1:0]  status;
    logic [2:0]  size_m1;
    logic [3:0]  st_mask;

    assign out_free = !m_valid || m_ready;
    // The execute stage finishes when the output register can take its result.
    assign adv = s1_vld_reg && out_free;
    assign s_ready = !clr_busy_reg && (!s1_vld_reg || out_free);

    // Register read for the incoming word with forwarding from the executing word.
    function automatic logic [31:0] rd_rf(input logic [4:0] idx,
                                          input logic [31:0] ram_val,
                                          input logic vld,
                                          input logic fwd, input logic [4:0] fidx,
                                          input logic [31:0] fval);
        logic [31:0] r;
        r = vld ? ram_val : 32'd0;
        if (fwd && fidx == idx) r = fval;
        if (idx == 5'd0 || 32'(idx) >= REG_COUNT) r = 32'd0;
        return r;
    endfunction

    logic [31:0] rf_ra, rf_rb;
    assign rf_ra = rf_mem[s_data.src_reg_a];
    assign rf_rb = rf_mem[s_data.src_reg_b];
    assign a_next = rd_rf(s_data.src_reg_a, rf_ra, rf_vld_reg[s_data.src_reg_a],
                          adv && wr, s1_reg.dest_reg, val);
    assign b_next = rd_rf(s_data.src_reg_b, rf_rb, rf_vld_reg[s_data.src_reg_b],
                          adv && wr, s1_reg.dest_reg, val);

    // Data memory read address is formed in the execute stage from the operand
    // register; to keep the bank read synchronous we read the banks in the same
    // clock edge that captures operands, using the forwarded operand and immediate.
    logic [31:0] addr_next;
    logic [BW-1:0] bidx_next [4];
    assign addr_next = a_next + s_data.immediate;
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            // Bank k holds byte (addr + j) with (addr + j) % 4 == k.
            logic [AW-1:0] ba;
            logic [1:0]    j;
            j = 2'(k) - addr_next[1:0];
            ba = AW'(addr_next) + AW'(j);
            bidx_next[k] = ba[AW-1:2];
        end
    end

    logic [7:0] rdb_reg [4];
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            rdb_reg[0] <= bank0[bidx_next[0]];
            rdb_reg[1] <= bank1[bidx_next[1]];
            rdb_reg[2] <= bank2[bidx_next[2]];
            rdb_reg[3] <= bank3[bidx_next[3]];
        end
    end

    // Store forwarding: a store that completes in the same edge as a load is read
    // overrides the stale bank byte.
    logic [7:0] fwd_byte [4];
    logic [3:0] fwd_hit_reg;
    logic [7:0] fwd_data_reg [4];
    logic [BW-1:0] st_idx [4];
    logic [7:0]    st_byte [4];

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            for (int k = 0; k < 4; k++) begin
                fwd_hit_reg[k]  <= adv && st_en && st_mask[k] && st_idx[k] == bidx_next[k];
                fwd_data_reg[k] <= st_byte[k];
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 4; k++)
            fwd_byte[k] = fwd_hit_reg[k] ? fwd_data_reg[k] : rdb_reg[k];
    end

    // Execute stage.
    assign addr = a_reg + s1_reg.immediate;
    always_comb begin
        for (int j = 0; j < 4; j++)
            bq[j] = fwd_byte[2'(addr[1:0] + 2'(j))];
    end

    function automatic logic lt_s(input logic [31:0] x, input logic [31:0] y);
        return $signed(x) < $signed(y);
    endfunction

    logic [31:0] imm;
    logic [31:0] ld_raw;
    logic        in_range;
    assign imm = s1_reg.immediate;
    assign ld_raw = {bq[3], bq[2], bq[1], bq[0]};
    assign in_range = {1'b0, addr} <= 33'(MEM_BYTES) - 33'(size_m1) - 33'd1;

    always_comb begin
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic        take;
        f3 = s1_reg.func_three;
        f7 = s1_reg.func_seven;
        take = 1'b0;
        val = 32'd0;
        wr = 1'b0;
        st_en = 1'b0;
        status = rv32i_exu_pkg::ST_OK;
        npc = pc_reg + 32'd4;
        size_m1 = 3'd0;
        case (s1_reg.major_opcode)
            rv32i_exu_pkg::OPC_OP: begin
                if (!(f7 == 7'd0 || (f7 == rv32i_exu_pkg::F7_ALT &&
                                     (f3 == 3'd0 || f3 == 3'd5)))) begin
                    status = rv32i_exu_pkg::ST_UNSUP;
                end else begin
                    wr = 1'b1;
                    case (f3)
                        3'd0: val = (f7 == rv32i_exu_pkg::F7_ALT) ? a_reg - b_reg
                                                                  : a_reg + b_reg;
                        3'd1: val = a_reg << b_reg[4:0];
                        3'd2: val = {31'd0, lt_s(a_reg, b_reg)};
                        3'd3: val = {31'd0, a_reg < b_reg};
                        3'd4: val = a_reg ^ b_reg;
                        3'd5: val = (f7 == rv32i_exu_pkg::F7_ALT)
                                  ? 32'($signed(a_reg) >>> b_reg[4:0])
                                  : a_reg >> b_reg[4:0];
                        3'd6: val = a_reg | b_reg;
                        default: val = a_reg & b_reg;
                    endcase
                end
            end
            rv32i_exu_pkg::OPC_OPIMM: begin
                wr = 1'b1;
                case (f3)
                    3'd0: val = a_reg + imm;
                    3'd1: val = a_reg << imm[4:0];
                    3'd2: val = {31'd0, lt_s(a_reg, imm)};
                    3'd3: val = {31'd0, a_reg < imm};
                    3'd4: val = a_reg ^ imm;
                    3'd5: val = imm[10] ? 32'($signed(a_reg) >>> imm[4:0])
                                        : a_reg >> imm[4:0];
                    3'd6: val = a_reg | imm;
                    default: val = a_reg & imm;
                endcase
            end
            rv32i_exu_pkg::OPC_LOAD: begin
                size_m1 = (f3[1:0] == 2'd0) ? 3'd0 : (f3[1:0] == 2'd1) ? 3'd1 : 3'd3;
                if (f3 == 3'd3 || f3 > 3'd5) begin
                    status = rv32i_exu_pkg::ST_UNSUP;
                end else if (!in_range) begin
                    status = rv32i_exu_pkg::ST_RANGE;
                end else begin
                    wr = 1'b1;
                    case (f3)
                        3'd0: val = {{24{ld_raw[7]}}, ld_raw[7:0]};
                        3'd1: val = {{16{ld_raw[15]}}, ld_raw[15:0]};
                        3'd4: val = {24'd0, ld_raw[7:0]};
                        3'd5: val = {16'd0, ld_raw[15:0]};
                        default: val = ld_raw;
                    endcase
                end
            end
            rv32i_exu_pkg::OPC_STORE: begin
                size_m1 = (f3[1:0] == 2'd0) ? 3'd0 : (f3[1:0] == 2'd1) ? 3'd1 : 3'd3;
                if (f3 > 3'd2) status = rv32i_exu_pkg::ST_UNSUP;
                else if (!in_range) status = rv32i_exu_pkg::ST_RANGE;
                else st_en = 1'b1;
            end
            rv32i_exu_pkg::OPC_BRANCH: begin
                case (f3)
                    3'd0: take = a_reg == b_reg;
                    3'd1: take = a_reg != b_reg;
                    3'd4: take = lt_s(a_reg, b_reg);
                    3'd5: take = !lt_s(a_reg, b_reg);
                    3'd6: take = a_reg < b_reg;
                    3'd7: take = a_reg >= b_reg;
                    default: status = rv32i_exu_pkg::ST_UNSUP;
                endcase
                if (take) npc = pc_reg + imm;
            end
            rv32i_exu_pkg::OPC_JAL: begin
                wr = 1'b1;
                val = pc_reg + 32'd4;
                npc = pc_reg + imm;
            end
            rv32i_exu_pkg::OPC_JALR: begin
                if (f3 != 3'd0) begin
                    status = rv32i_exu_pkg::ST_UNSUP;
                end else begin
                    wr = 1'b1;
                    val = pc_reg + 32'd4;
                    npc = (a_reg + imm) & ~32'd1;
                end
            end
            rv32i_exu_pkg::OPC_LUI: begin
                wr = 1'b1;
                val = imm;
            end
            rv32i_exu_pkg::OPC_AUIPC: begin
                wr = 1'b1;
                val = pc_reg + imm;
            end
            default: status = rv32i_exu_pkg::ST_UNSUP;
        endcase
        if (!(wr && s1_reg.dest_reg != 5'd0 && 32'(s1_reg.dest_reg) < REG_COUNT)) begin
            wr = 1'b0;
            val = 32'd0;
        end
    end

    // Store byte lanes per bank.
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            logic [1:0]    j;
            logic [AW-1:0] ba;
            j = 2'(k) - addr[1:0];
            ba = AW'(addr) + AW'(j);
            st_idx[k]  = ba[AW-1:2];
            st_mask[k] = {1'b0, j} <= size_m1;
            st_byte[k] = b_reg[8*j +: 8];
        end
    end

    // Memory writes: clearing pass after reset, then stores.
    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            bank0[clr_cnt_reg[BW-1:0]] <= 8'd0;
            bank1[clr_cnt_reg[BW-1:0]] <= 8'd0;
            bank2[clr_cnt_reg[BW-1:0]] <= 8'd0;
            bank3[clr_cnt_reg[BW-1:0]] <= 8'd0;
        end else if (adv && st_en) begin
            if (st_mask[0]) bank0[st_idx[0]] <= st_byte[0];
            if (st_mask[1]) bank1[st_idx[1]] <= st_byte[1];
            if (st_mask[2]) bank2[st_idx[2]] <= st_byte[2];
            if (st_mask[3]) bank3[st_idx[3]] <= st_byte[3];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && wr) rf_mem[s1_reg.dest_reg] <= val;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
            rf_vld_reg   <= '0;
            pc_reg       <= 32'd0;
            s1_vld_reg   <= 1'b0;
            m_valid      <= 1'b0;
        end else begin
            if (clr_busy_reg) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == (BW+1)'(BANK_DEPTH - 1)) clr_busy_reg <= 1'b0;
            end
            if (adv && wr) rf_vld_reg[s1_reg.dest_reg] <= 1'b1;
            if (adv) pc_reg <= npc;
            if (s_valid && s_ready) s1_vld_reg <= 1'b1;
            else if (adv) s1_vld_reg <= 1'b0;
            if (adv) m_valid <= 1'b1;
            else if (m_ready) m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            s1_reg <= s_data;
            a_reg  <= a_next;
            b_reg  <= b_next;
        end
        if (adv) begin
            m_data.next_pc       <= npc;
            m_data.reg_written   <= wr;
            m_data.written_index <= wr ? s1_reg.dest_reg : 5'd0;
            m_data.written_value <= val;
            m_data.exec_status   <= status;
        end
    end

endmodule
